FILE: rtl/stsf_pkg.sv
// ----------------------------------------------------------------------------
// Subarray target sum finder package
// Transaction types, fixed field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package stsf_pkg;

  localparam int unsigned ElemW     = 16;
  localparam int unsigned TargetW   = 21;
  localparam int unsigned OutIndexW = 5;

  typedef struct packed {
    logic signed [ElemW-1:0] element_value;
    logic                    array_end;
  } in_t;

  typedef struct packed {
    logic [OutIndexW-1:0] start_index;
    logic [OutIndexW-1:0] end_index;
    logic                 last_match;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take an input transaction
    logic calc;       // form the wanted prefix value
    logic step;       // advance the scan pointer
    logic capture;    // hold the current slot as the pending match
    logic push;       // move the pending match into the output register
    logic push_last;  // the pushed match is the final one of the element
    logic finish;     // commit the element count, clearing at array end
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic beyond;     // element count has reached capacity
    logic scan_done;  // every stored slot has been compared
    logic match;      // current slot equals the wanted prefix value
    logic pend_valid; // a match is waiting to be output
    logic out_free;   // the output register can take a transaction
  } sts_t;

endpackage

FILE: rtl/stsf_dp.sv
// ----------------------------------------------------------------------------
// Subarray target sum finder datapath
// Prefix store, running sum, scan pointer, compare and output register.
// ----------------------------------------------------------------------------
module stsf_dp #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  stsf_pkg::cmd_t                      cmd_i,
  output stsf_pkg::sts_t                      sts_o,
  input  stsf_pkg::in_t                       in_data_i,
  input  logic                                cfg_we_i,
  input  logic signed [stsf_pkg::TargetW-1:0] cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output stsf_pkg::out_t                      out_data_o
);

  localparam int unsigned SumW  = stsf_pkg::ElemW + $clog2(MAX_LEN);
  localparam int unsigned DiffW = ((SumW > stsf_pkg::TargetW) ? SumW : stsf_pkg::TargetW) + 1;
  localparam int unsigned CntW  = $clog2(MAX_LEN + 1);
  localparam int unsigned IdxW  = $clog2(MAX_LEN);

  logic signed [SumW-1:0]               sum_q, sum_d;
  logic        [CntW-1:0]               cnt_q, cnt_d;
  logic        [CntW-1:0]               elem_idx_q;
  logic                                 last_q;
  logic signed [stsf_pkg::TargetW-1:0]  target_q;
  logic signed [DiffW-1:0]              want_q;
  logic        [CntW-1:0]               scan_q;
  logic        [CntW-1:0]               pend_q;
  logic                                 pend_vld_q;
  logic                                 out_vld_q;
  stsf_pkg::out_t                       out_q;
  logic signed [SumW-1:0]               rd_q;
  logic signed [SumW-1:0]               mem [MAX_LEN];

  logic signed [SumW-1:0] elem_ext;
  logic signed [SumW-1:0] sum_next;
  logic        [CntW-1:0] rd_addr;
  logic                   beyond;
  logic                   store_en;
  logic        [IdxW-1:0] wr_idx;
  logic                   out_free;

  assign elem_ext = SumW'(in_data_i.element_value);
  assign sum_next = sum_q + elem_ext;
  assign beyond   = (cnt_q >= CntW'(MAX_LEN));
  // The prefix after the final slot is never matched, so it is not kept.
  assign store_en = cmd_i.load && !beyond && (cnt_q < CntW'(MAX_LEN - 1));
  assign wr_idx   = IdxW'(cnt_q + CntW'(1));
  // The read address moves ahead with the scan pointer, so during a scan the
  // registered read data belongs to the slot that scan_q names.
  assign rd_addr  = cmd_i.step ? (scan_q + CntW'(1)) : scan_q;
  assign out_free = !out_vld_q || out_ready_i;

  assign sts_o.beyond     = beyond;
  assign sts_o.scan_done  = (scan_q > elem_idx_q);
  assign sts_o.match      = (DiffW'(rd_q) == want_q);
  assign sts_o.pend_valid = pend_vld_q;
  assign sts_o.out_free   = out_free;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem[wr_idx] <= sum_next;
    end
    // Slot zero is the empty prefix and always reads as zero.
    if (rd_addr == '0) begin
      rd_q <= '0;
    end else begin
      rd_q <= mem[rd_addr[IdxW-1:0]];
    end
  end

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      if (!beyond) begin
        sum_d = sum_next;
      end else if (in_data_i.array_end) begin
        sum_d = '0;
        cnt_d = '0;
      end
    end else if (cmd_i.finish) begin
      if (last_q) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        cnt_d = elem_idx_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      cnt_q      <= '0;
      target_q   <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        target_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        pend_vld_q <= 1'b0;
      end else if (cmd_i.capture) begin
        pend_vld_q <= 1'b1;
      end else if (cmd_i.push) begin
        pend_vld_q <= 1'b0;
      end
      if (cmd_i.push) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      elem_idx_q <= cnt_q;
      last_q     <= in_data_i.array_end;
      scan_q     <= '0;
    end
    if (cmd_i.calc) begin
      want_q <= DiffW'(sum_q) - DiffW'(target_q);
    end
    if (cmd_i.step) begin
      scan_q <= scan_q + CntW'(1);
    end
    if (cmd_i.capture) begin
      pend_q <= scan_q;
    end
    if (cmd_i.push) begin
      out_q.start_index <= stsf_pkg::OutIndexW'(pend_q);
      out_q.end_index   <= stsf_pkg::OutIndexW'(elem_idx_q);
      out_q.last_match  <= cmd_i.push_last;
    end
  end

endmodule

FILE: rtl/stsf_ctrl.sv
// ----------------------------------------------------------------------------
// Subarray target sum finder controller
// Sequences acceptance, target subtraction and the scan over stored prefixes.
// ----------------------------------------------------------------------------
module stsf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  stsf_pkg::sts_t sts_i,
  output stsf_pkg::cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCalc = 2'd1;
  localparam logic [1:0] StScan = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!sts_i.beyond) begin
            state_d = StCalc;
          end
        end
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        state_d    = StScan;
      end
      StScan: begin
        if (sts_i.scan_done) begin
          // The held match, if any, is the final one of this element.
          if (!sts_i.pend_valid) begin
            cmd_o.finish = 1'b1;
            state_d      = StIdle;
          end else if (sts_i.out_free) begin
            cmd_o.push      = 1'b1;
            cmd_o.push_last = 1'b1;
            cmd_o.finish    = 1'b1;
            state_d         = StIdle;
          end
        end else if (sts_i.match && sts_i.pend_valid) begin
          // A newer match proves the held one is not the last.
          if (sts_i.out_free) begin
            cmd_o.push    = 1'b1;
            cmd_o.capture = 1'b1;
            cmd_o.step    = 1'b1;
          end
        end else begin
          cmd_o.capture = sts_i.match;
          cmd_o.step    = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/subarray_target_sum_finder.sv
// ----------------------------------------------------------------------------
// Subarray target sum finder
// Reports every contiguous subarray of an element stream that sums to a target.
// ----------------------------------------------------------------------------
// Each input transaction carries one signed element; the block adds it to a
// running prefix sum and reports, as output transactions, every earlier
// prefix (the empty prefix included) equal to the running sum minus the
// target, each naming the start and end index of the matching subarray, in
// increasing start order with the final one flagged by last_match. An element
// within capacity is accepted, then the wanted prefix value is formed and the
// empty prefix fetched, then the stored prefixes are compared, one stored
// prefix a cycle, and the element is closed; the scan stalls while a result
// waits for the output register to drain. An element beyond MAX_LEN is
// accepted without a scan and yields no result. After an element that carries
// array_end the running sum and the element count return to zero. The target
// register may be written only while no element is in progress.
module subarray_target_sum_finder #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Element input channel.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  stsf_pkg::in_t                       in_data_i,
  // Result output channel.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output stsf_pkg::out_t                      out_data_o,
  // Target sum register write port.
  input  logic                                cfg_we_i,
  input  logic signed [stsf_pkg::TargetW-1:0] cfg_data_i
);

  stsf_pkg::cmd_t cmd;
  stsf_pkg::sts_t sts;

  // The controller decides when to accept, scan and emit; the datapath holds
  // the prefix store, the sums and the output register.
  stsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stsf_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
